// ===== rtl/isotp_receive_reassembler_top_macros.svh =====
// assertion macros for the checker file
`ifndef ISOTP_RECEIVE_REASSEMBLER_TOP_MACROS_SVH
`define ISOTP_RECEIVE_REASSEMBLER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ISOTP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ISOTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/isotp_rx_pkg.sv =====
// types, codes and helpers for the iso-tp receive reassembler
package isotp_rx_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FC_BLOCK_SIZE      = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FC_SEPARATION_TIME = 4'd1;

   localparam logic [3:0] PCI_SINGLE  = 4'h0;
   localparam logic [3:0] PCI_FIRST   = 4'h1;
   localparam logic [3:0] PCI_CONSEC  = 4'h2;
   localparam logic [3:0] PCI_FLOWCTL = 4'h3;

   localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_IGNORED   = 2'd2;

   localparam logic [1:0] FC_FLAG_CTS      = 2'd0;
   localparam logic [1:0] FC_FLAG_OVERFLOW = 2'd2;

   localparam logic [3:0] CAN_MAX_BYTES = 4'd8;

   typedef struct packed {
      logic [63:0] frame_bytes;
      logic [3:0]  frame_length;
   } frame_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        fc_send;
      logic [1:0]  fc_flag;
      logic [55:0] data_bytes;
      logic [2:0]  data_count;
      logic [11:0] data_offset;
      logic        message_start;
      logic        message_done;
      logic [11:0] message_length;
      logic        sequence_error;
   } result_type;

   // keeps the low count bytes of a seven-byte payload
   function automatic logic [55:0] byte_mask(input logic [2:0] count);
      logic [55:0] mask;
      mask = '0;
      for (int i = 0; i < 7; i++) begin
         mask[8*i +: 8] = (3'(i) < count) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

endpackage

// ===== rtl/isotp_rx_input.sv =====
// input register stage for incoming frames
module isotp_rx_input
   import isotp_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  frame_type   req_frame,
   input  logic        advance,
   output logic        frame_valid,
   output frame_type   frame
);

   logic      valid_ff;
   logic      valid_in;
   frame_type frame_ff;

   // only stall when a frame is held and the result side cannot take it
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         frame_ff <= req_frame;
      end
   end

   assign frame_valid = valid_ff;
   assign frame       = frame_ff;

endmodule

// ===== rtl/isotp_rx_engine.sv =====
// pci decode and reception state for the reassembler
module isotp_rx_engine
   import isotp_rx_pkg::*;
#(
   parameter int unsigned MAX_MESSAGE_LENGTH = 4095
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  frame_type  frame,
   output result_type result
);

   localparam logic [11:0] MaxLen = 12'(MAX_MESSAGE_LENGTH);

   logic [11:0] expected_total_ff, expected_total_in;
   logic [12:0] bytes_received_ff, bytes_received_in;
   logic [3:0]  next_sequence_ff, next_sequence_in;
   logic        receiving_ff, receiving_in;

   logic [3:0]  len;
   logic [3:0]  pci_type;
   logic [3:0]  nib;
   logic [11:0] total;
   logic [2:0]  ff_cnt;
   logic [12:0] exp_ext;
   logic [12:0] remain;
   logic [2:0]  cf_raw;
   logic [2:0]  cf_cnt;
   logic [12:0] br_sum;

   assign len      = (frame.frame_length > CAN_MAX_BYTES) ? CAN_MAX_BYTES : frame.frame_length;
   assign pci_type = frame.frame_bytes[7:4];
   assign nib      = frame.frame_bytes[3:0];
   assign total    = {nib, frame.frame_bytes[15:8]};
   assign ff_cnt   = 3'(len - 4'd2);
   assign exp_ext  = {1'b0, expected_total_ff};
   assign remain   = (exp_ext > bytes_received_ff) ? (exp_ext - bytes_received_ff) : 13'd0;
   assign cf_raw   = 3'(len - 4'd1);
   // trim the last consecutive frame to what the message still needs
   assign cf_cnt   = (remain < {10'd0, cf_raw}) ? remain[2:0] : cf_raw;
   assign br_sum   = bytes_received_ff + {10'd0, cf_cnt};

   always_comb begin
      result            = '0;
      expected_total_in = expected_total_ff;
      bytes_received_in = bytes_received_ff;
      next_sequence_in  = next_sequence_ff;
      receiving_in      = receiving_ff;
      if (len == 4'd0) begin
         result.status = STATUS_MALFORMED;
      end else begin
         unique case (pci_type)
            PCI_SINGLE: begin
               if (nib == 4'd0 || nib[3] || ({1'b0, len} < ({1'b0, nib} + 5'd1))) begin
                  result.status = STATUS_MALFORMED;
               end else begin
                  receiving_in          = 1'b0;
                  result.data_bytes     = frame.frame_bytes[63:8] & byte_mask(nib[2:0]);
                  result.data_count     = nib[2:0];
                  result.message_start  = 1'b1;
                  result.message_done   = 1'b1;
                  result.message_length = {9'd0, nib[2:0]};
               end
            end
            PCI_FIRST: begin
               if (len < 4'd2 || total < 12'd8 || total > MaxLen) begin
                  result.status = STATUS_MALFORMED;
               end else begin
                  expected_total_in     = total;
                  bytes_received_in     = {10'd0, ff_cnt};
                  next_sequence_in      = 4'd1;
                  receiving_in          = 1'b1;
                  result.fc_send        = 1'b1;
                  result.fc_flag        = FC_FLAG_CTS;
                  result.data_bytes     = {8'h00, frame.frame_bytes[63:16]} & byte_mask(ff_cnt);
                  result.data_count     = ff_cnt;
                  result.message_start  = 1'b1;
                  result.message_length = total;
               end
            end
            PCI_CONSEC: begin
               if (!receiving_ff) begin
                  result.status = STATUS_IGNORED;
               end else if (nib != next_sequence_ff) begin
                  receiving_in          = 1'b0;
                  result.fc_send        = 1'b1;
                  result.fc_flag        = FC_FLAG_OVERFLOW;
                  result.sequence_error = 1'b1;
               end else begin
                  result.data_bytes  = frame.frame_bytes[63:8] & byte_mask(cf_cnt);
                  result.data_count  = cf_cnt;
                  result.data_offset = (cf_cnt != 3'd0) ? bytes_received_ff[11:0] : 12'd0;
                  bytes_received_in  = br_sum;
                  next_sequence_in   = next_sequence_ff + 4'd1;
                  if (br_sum >= exp_ext) begin
                     receiving_in          = 1'b0;
                     result.message_done   = 1'b1;
                     result.message_length = expected_total_ff;
                  end else begin
                     result.fc_send = 1'b1;
                     result.fc_flag = FC_FLAG_CTS;
                  end
               end
            end
            PCI_FLOWCTL: begin
               result.status = (len < 4'd3) ? STATUS_MALFORMED : STATUS_IGNORED;
            end
            default: begin
               result.status = STATUS_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_total_ff <= '0;
         bytes_received_ff <= '0;
         next_sequence_ff  <= '0;
         receiving_ff      <= 1'b0;
      end else if (fire) begin
         expected_total_ff <= expected_total_in;
         bytes_received_ff <= bytes_received_in;
         next_sequence_ff  <= next_sequence_in;
         receiving_ff      <= receiving_in;
      end
   end

endmodule

// ===== rtl/isotp_rx_output.sv =====
// result register stage towards the consumer
module isotp_rx_output
   import isotp_rx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_result,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         result_ff <= in_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== rtl/isotp_receive_reassembler_top.sv =====
// iso-tp receive reassembler top level
//
//   channel | direction | handshake          | beat
//   req_    | in        | req_valid/stall    | one can frame
//   rsp_    | out       | rsp_valid/stall    | one decode result
//   csr_    | in        | csr_valid/ready    | one register write
//
// one frame a cycle while rsp_stall is low; each result leaves after its beat is taken
// through the input register, then decode and state update into the result register
// the state update loop in the engine sets that rate
// reset is synchronous and clears the valids and the reception state
// rsp_stall holds the result; req_stall rises only with both stages full
module isotp_receive_reassembler_top
   import isotp_rx_pkg::*;
#(
   parameter int unsigned MAX_MESSAGE_LENGTH = 4095
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [63:0]                req_frame_bytes,
   input  logic [3:0]                 req_frame_length,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_fc_send,
   output logic [1:0]                 rsp_fc_flag,
   output logic [55:0]                rsp_data_bytes,
   output logic [2:0]                 rsp_data_count,
   output logic [11:0]                rsp_data_offset,
   output logic                       rsp_message_start,
   output logic                       rsp_message_done,
   output logic [11:0]                rsp_message_length,
   output logic                       rsp_sequence_error,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_data
);

   frame_type  req_frame;
   frame_type  frame;
   logic       frame_valid;
   logic       advance;
   logic       fire;
   result_type result;
   result_type rsp_result;

   // held for the flow control transmitter
   logic [7:0] fc_block_size_ff;
   logic [7:0] fc_separation_time_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_block_size_ff      <= '0;
         fc_separation_time_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FC_BLOCK_SIZE) begin
            fc_block_size_ff <= csr_data;
         end else if (csr_index == CSR_FC_SEPARATION_TIME) begin
            fc_separation_time_ff <= csr_data;
         end
      end
   end

   assign req_frame.frame_bytes  = req_frame_bytes;
   assign req_frame.frame_length = req_frame_length;

   isotp_rx_input u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_frame   (req_frame),
      .advance     (advance),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   assign fire = frame_valid && advance;

   isotp_rx_engine #(
      .MAX_MESSAGE_LENGTH (MAX_MESSAGE_LENGTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .frame  (frame),
      .result (result)
   );

   isotp_rx_output u_output (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (frame_valid),
      .in_result  (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_status         = rsp_result.status;
   assign rsp_fc_send        = rsp_result.fc_send;
   assign rsp_fc_flag        = rsp_result.fc_flag;
   assign rsp_data_bytes     = rsp_result.data_bytes;
   assign rsp_data_count     = rsp_result.data_count;
   assign rsp_data_offset    = rsp_result.data_offset;
   assign rsp_message_start  = rsp_result.message_start;
   assign rsp_message_done   = rsp_result.message_done;
   assign rsp_message_length = rsp_result.message_length;
   assign rsp_sequence_error = rsp_result.sequence_error;

endmodule

// ===== rtl/isotp_rx_checker.sv =====
// port-level checks for the reassembler and their bind
`include "isotp_receive_reassembler_top_macros.svh"

module isotp_rx_port_checks
   import isotp_rx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_fc_send,
   input logic [1:0]  rsp_fc_flag,
   input logic [55:0] rsp_data_bytes,
   input logic [2:0]  rsp_data_count,
   input logic [11:0] rsp_data_offset,
   input logic        rsp_message_start,
   input logic        rsp_message_done,
   input logic [11:0] rsp_message_length,
   input logic        rsp_sequence_error
);

   logic [90:0] rsp_beat;
   logic        rsp_held;
   logic        rsp_rejected;
   logic        fields_clear;
   logic        overflow_abort;
   logic        single_whole;

   assign rsp_beat = {rsp_status, rsp_fc_send, rsp_fc_flag, rsp_data_bytes, rsp_data_count,
                      rsp_data_offset, rsp_message_start, rsp_message_done,
                      rsp_message_length, rsp_sequence_error};
   assign rsp_held     = rsp_valid && rsp_stall;
   assign rsp_rejected = rsp_valid && rsp_status != STATUS_ACCEPTED;
   assign fields_clear = !rsp_fc_send && rsp_data_count == 3'd0 && !rsp_message_start &&
                         !rsp_message_done && !rsp_sequence_error;
   assign overflow_abort = rsp_fc_send && rsp_fc_flag == FC_FLAG_OVERFLOW &&
                           rsp_data_count == 3'd0 && !rsp_message_done;
   assign single_whole = !rsp_fc_send && rsp_message_length == {9'd0, rsp_data_count} &&
                         rsp_data_offset == 12'd0;

   // a stalled result beat keeps its contents
   `ISOTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_beat),
                      "result changed while stalled")

   // rejected or ignored frames carry nothing but their status
   `ISOTP_ASSERT_IMPL(a_reject_empty, clock, reset, rsp_rejected, fields_clear,
                      "non-accepted result has fields set")

   // a sequence error aborts with an overflow flow control and no data
   `ISOTP_ASSERT_IMPL(a_seq_overflow, clock, reset, rsp_valid && rsp_sequence_error,
                      overflow_abort, "sequence error without overflow")

   // a single frame message is exactly its forwarded bytes
   `ISOTP_ASSERT_IMPL(a_single_frame, clock, reset,
                      rsp_valid && rsp_message_start && rsp_message_done, single_whole,
                      "single frame length mismatch")

endmodule

bind isotp_receive_reassembler_top isotp_rx_port_checks u_isotp_rx_checker (.*);
